/* rtl/sip_pkg.sv */
// Shared types and codes for the skin influence slot packer.
// Depends on nothing; every other file of the block uses it.
package sip_pkg;

  localparam int WEIGHT_W = 16;
  localparam int BONE_W   = 16;
  localparam int TOTAL_W  = 18;
  localparam int NORM_W   = 17;
  localparam int QUO_W    = 31;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_BONE_COUNT   = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_WNEG    = 3'd1,
    ST_VOUT    = 3'd2,
    ST_BOUT    = 3'd3,
    ST_FULL    = 3'd4,
    ST_READ    = 3'd5,
    ST_CLEARED = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_EVAL,
    S_DIV,
    S_DONE
  } seq_state_t;

endpackage

/* rtl/sip_if.sv */
// Handshake channels of the skin influence slot packer.
// Depends on sip_pkg for the status type.
interface sip_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [15:0]         vertex;
  logic [15:0]         bone;
  logic signed [15:0]  weight;
  logic [2:0]          slot;
  modport source (output valid, mode, vertex, bone, weight, slot, input ready);
  modport sink (input valid, mode, vertex, bone, weight, slot, output ready);
endinterface

interface sip_out_if;
  logic                valid;
  logic                ready;
  sip_pkg::status_t    status;
  logic [15:0]         bone_index;
  logic [16:0]         norm_weight;
  modport source (output valid, status, bone_index, norm_weight, input ready);
  modport sink (input valid, status, bone_index, norm_weight, output ready);
endinterface

interface sip_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/sip_div.sv */
// Restoring divider, one quotient bit per cycle, for weight normalisation.
// Depends on sip_pkg for the operand widths.
module sip_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sip_pkg::QUO_W-1:0]      dividend,
  input  logic [sip_pkg::TOTAL_W-1:0]    divisor,
  output logic                           done,
  output logic [sip_pkg::NORM_W-1:0]     quotient
);
  import sip_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TOTAL_W:0]   rem_r, rem_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [TOTAL_W-1:0] dsr_r, dsr_nxt;
  logic [TOTAL_W:0]   rem_sh;
  logic               fits;

  always_comb begin
    rem_sh   = {rem_r[TOTAL_W-1:0], quo_r[QUO_W-1]};
    fits     = rem_sh >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sh - {1'b0, dsr_r} : rem_sh;
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[NORM_W-1:0];

endmodule

/* rtl/skin_influence_slot_packer.sv */
// Top level of the skin influence slot packer: sequencer, tables and output register.
// Depends on sip_pkg, the channels in sip_if and the divider sip_div.
//
// Usage. Requests arrive on in_chan: an add request stores a (bone, weight) pair in
// the next free slot of its vertex, a read request returns one slot's bone and its
// weight divided by the vertex total (unsigned Q1.16, truncated), and a clear request
// zeroes every vertex's slot count and weight total. Every request except the unused
// mode code gives exactly one result on out_chan. cfg_chan writes vertex_count and
// bone_count; it is always ready and should be used only while the block is idle.
// Timing. One request is handled at a time and in_chan is not ready meanwhile. An add
// passes through S_FETCH, S_EVAL and S_DONE; a read of a filled slot also waits in
// S_DIV for the 31 steps of the one-bit-per-cycle divider; a clear passes through
// S_CLEAR, which zeroes one entry at a time through the single write port of the
// per-vertex table, and then S_DONE. in_chan is ready again from the edge that
// raises the result.
// Reset. After rst_n the block runs a clearing pass over every entry of the
// per-vertex table and accepts no request until it has finished.
// Stall. A result waits in the output register while out_chan is stalled; the next
// request may be accepted meanwhile, and its result waits until that register is free.
module skin_influence_slot_packer #(
  parameter int MAX_VERTS = 4096,
  parameter int SLOTS     = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  sip_in_if.sink    in_chan,
  sip_out_if.source out_chan,
  sip_cfg_if.sink   cfg_chan
);
  import sip_pkg::*;

  localparam int VW    = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int FW    = $clog2(SLOTS + 1);
  localparam int DEPTH = MAX_VERTS * SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW    = FW + TOTAL_W;
  localparam int SW    = 31;
  localparam logic [16:0] MAXV = 17'(MAX_VERTS);

  seq_state_t state_r, state_nxt;

  // Accepted request.
  logic [1:0]         mode_r;
  logic [15:0]        vtx_r;
  logic [15:0]        bone_r;
  logic [15:0]        wgt_r;
  logic [2:0]         slot_r;

  logic [12:0]        vcount_r;
  logic [15:0]        bcount_r;

  // Clearing pass.
  logic [VW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic               clr_cmd_r, clr_cmd_nxt;

  // Result waiting for the output register.
  status_t            res_status_r, res_status_nxt;
  logic [15:0]        res_bone_r, res_bone_nxt;
  logic [NORM_W-1:0]  res_norm_r, res_norm_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r;
  logic [15:0]        out_bone_r;
  logic [NORM_W-1:0]  out_norm_r;
  logic               out_load;

  // Tables: per-vertex fill count and total, and the slot store.
  logic [MW-1:0]      meta_mem [MAX_VERTS];
  logic [MW-1:0]      meta_rd_r;
  logic               meta_we;
  logic [VW-1:0]      meta_waddr;
  logic [MW-1:0]      meta_wdata;
  logic [SW-1:0]      store_mem [DEPTH];
  logic [SW-1:0]      store_rd_r;
  logic               store_we;
  logic [AW-1:0]      store_waddr;
  logic [AW-1:0]      store_raddr;

  logic [FW-1:0]      fill;
  logic [TOTAL_W-1:0] total;
  logic               vtx_in;
  logic               w_pos;
  logic               bone_in;
  logic               full;
  logic               slot_empty;
  logic               div_start;
  logic               div_done;
  logic [NORM_W-1:0]  div_quo;
  logic               accept;
  logic               clr_last;

  assign accept    = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign fill     = meta_rd_r[MW-1:TOTAL_W];
  assign total    = meta_rd_r[TOTAL_W-1:0];
  assign vtx_in   = ({1'b0, vtx_r} < {4'b0, vcount_r}) && ({1'b0, vtx_r} < MAXV);
  assign w_pos    = (wgt_r != '0) && !wgt_r[15];
  assign bone_in  = bone_r < bcount_r;
  assign full     = 32'(fill) >= 32'(SLOTS);
  assign slot_empty = (32'(slot_r) >= 32'(SLOTS)) || (32'(slot_r) >= 32'(fill))
                      || (total == '0);
  assign clr_last = (32'(clr_cnt_r) == 32'(MAX_VERTS - 1));

  assign store_raddr = AW'(32'(vtx_r[VW-1:0]) * 32'(SLOTS) + 32'(slot_r));
  assign store_waddr = AW'(32'(vtx_r[VW-1:0]) * 32'(SLOTS) + 32'(fill));
  assign out_load    = !out_valid_r || out_chan.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_last) state_nxt = clr_cmd_r ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_chan.mode)
            MODE_ADD:   state_nxt = S_FETCH;
            MODE_READ:  state_nxt = S_FETCH;
            MODE_CLEAR: state_nxt = S_CLEAR;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_FETCH: state_nxt = S_EVAL;
      S_EVAL: begin
        if (mode_r == MODE_READ && vtx_in && !slot_empty) state_nxt = S_DIV;
        else state_nxt = S_DONE;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    clr_cmd_nxt    = clr_cmd_r;
    res_status_nxt = res_status_r;
    res_bone_nxt   = res_bone_r;
    res_norm_nxt   = res_norm_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    meta_we        = 1'b0;
    meta_waddr     = clr_cnt_r;
    meta_wdata     = '0;
    store_we       = 1'b0;
    div_start      = 1'b0;
    case (state_r)
      S_CLEAR: begin
        meta_we     = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          res_status_nxt = ST_CLEARED;
          res_bone_nxt   = '0;
          res_norm_nxt   = '0;
        end
      end
      S_IDLE: begin
        clr_cnt_nxt = '0;
        clr_cmd_nxt = 1'b1;
      end
      S_EVAL: begin
        res_bone_nxt = '0;
        res_norm_nxt = '0;
        if (mode_r == MODE_ADD) begin
          if (!w_pos) res_status_nxt = ST_WNEG;
          else if (!vtx_in) res_status_nxt = ST_VOUT;
          else if (!bone_in) res_status_nxt = ST_BOUT;
          else if (full) res_status_nxt = ST_FULL;
          else begin
            res_status_nxt = ST_STORED;
            store_we   = 1'b1;
            meta_we    = 1'b1;
            meta_waddr = vtx_r[VW-1:0];
            meta_wdata = {fill + 1'b1, TOTAL_W'(total + TOTAL_W'(wgt_r))};
          end
        end else begin
          res_status_nxt = vtx_in ? ST_READ : ST_VOUT;
          div_start      = vtx_in && !slot_empty;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_bone_nxt = store_rd_r[30:15];
          res_norm_nxt = div_quo;
        end
      end
      S_DONE: begin
        if (out_load) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_cmd_r   <= 1'b0;
      out_valid_r <= 1'b0;
      vcount_r    <= '0;
      bcount_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          CFG_VERTEX_COUNT: vcount_r <= cfg_chan.data[12:0];
          CFG_BONE_COUNT:   bcount_r <= cfg_chan.data;
          default: ;
        endcase
      end
    end
    if (accept) begin
      mode_r <= in_chan.mode;
      vtx_r  <= in_chan.vertex;
      bone_r <= in_chan.bone;
      wgt_r  <= in_chan.weight;
      slot_r <= in_chan.slot;
    end
    res_status_r <= res_status_nxt;
    res_bone_r   <= res_bone_nxt;
    res_norm_r   <= res_norm_nxt;
    if (state_r == S_DONE && out_load) begin
      out_status_r <= res_status_r;
      out_bone_r   <= res_bone_r;
      out_norm_r   <= res_norm_r;
    end
  end

  // Per-vertex table, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    meta_rd_r <= meta_mem[vtx_r[VW-1:0]];
  end

  // Slot store, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_waddr] <= {bone_r, wgt_r[14:0]};
    store_rd_r <= store_mem[store_raddr];
  end

  sip_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({store_rd_r[14:0], 16'b0}),
    .divisor  (total),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.bone_index  = out_bone_r;
  assign out_chan.norm_weight = out_norm_r;

endmodule

/* rtl/sip_chk.sv */
// Port-level checks for the skin influence slot packer, bound to its top level.
// Depends on sip_pkg for the status and mode codes.
module sip_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [1:0]       in_mode,
  input logic             out_valid,
  input logic             out_ready,
  input sip_pkg::status_t out_status,
  input logic [15:0]      out_bone,
  input logic [16:0]      out_norm
);
  import sip_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_bone)
    && $stable(out_norm))
    else $error("result changed while stalled");

  // Requests that produce a result are handled one at a time; the unused mode code
  // is dropped at once and leaves the input ready.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready
    && (in_mode == MODE_ADD || in_mode == MODE_READ || in_mode == MODE_CLEAR)
    |=> !in_ready)
    else $error("request accepted while busy");

  // Only a read carries a bone and a weight.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_READ |-> out_bone == '0 && out_norm == '0)
    else $error("non-read result carries data");

endmodule

bind skin_influence_slot_packer sip_chk u_sip_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_mode    (in_chan.mode),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_bone   (out_chan.bone_index),
  .out_norm   (out_chan.norm_weight)
);
